### rtl/core/cvsq_pkg.sv
// ----------------------------------------------------------------------------
// cvsq_pkg : constants and tables for the cv scale quantiser
// Sizes, the reciprocal used for the octave split and the table that maps a
// semitone index back to a Q1.15 magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

package cvsq_pkg;

   localparam int NOTES_PER_OCTAVE = 12;
   localparam int OCTAVE_SPAN      = 5;

   localparam int SAMPLE_W = 16;
   localparam int MASK_W   = 12;
   localparam int NOTE_W   = 4;

   // semitones across the whole span
   localparam int SPAN_SEMIS = NOTES_PER_OCTAVE * OCTAVE_SPAN;
   localparam int SEMIS_W    = $clog2(SPAN_SEMIS + 1);
   localparam int OCT_W      = $clog2(OCTAVE_SPAN + 1);
   localparam int MAGIN_W    = SAMPLE_W + 1;
   localparam int PROD_W     = MAGIN_W + SEMIS_W + 1;

   // octave = (semis * OCT_RECIP) >> OCT_SHIFT, exact for every semis value
   localparam int OCT_SHIFT = SEMIS_W + $clog2(NOTES_PER_OCTAVE);
   localparam int OCT_RECIP = ((1 << OCT_SHIFT) + NOTES_PER_OCTAVE - 1) / NOTES_PER_OCTAVE;
   localparam int RECIP_W   = $clog2(OCT_RECIP + 1);
   localparam int OPROD_W   = SEMIS_W + RECIP_W;

   // a reused note may reach past the top of the span
   localparam int TOTAL_MAX   = OCTAVE_SPAN * NOTES_PER_OCTAVE + (1 << NOTE_W) - 1;
   localparam int TOTAL_COUNT = TOTAL_MAX + 1;
   localparam int TOTAL_W     = $clog2(TOTAL_COUNT);
   localparam int MAG_W       = SAMPLE_W + 1;

   localparam logic [MAG_W-1:0] POS_FULL = MAG_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic [MAG_W-1:0] NEG_FULL = MAG_W'(1 << (SAMPLE_W - 1));

   typedef logic [MAG_W-1:0] mag_lut_type [TOTAL_COUNT];

   // semitone index to Q1.15 magnitude, rounded half away from zero
   function automatic mag_lut_type build_mag_lut();
      mag_lut_type lut;
      for (int i = 0; i < TOTAL_COUNT; i++) begin
         lut[i] = MAG_W'((i * (2 << (SAMPLE_W - 1)) + SPAN_SEMIS) / (2 * SPAN_SEMIS));
      end
      return lut;
   endfunction

   localparam mag_lut_type MAG_LUT = build_mag_lut();

endpackage

`default_nettype wire

### rtl/core/cv_scale_quantizer_unit.sv
// ----------------------------------------------------------------------------
// cv_scale_quantizer_unit : pitch quantiser for Q1.15 control voltage
// Scales the magnitude to semitones, snaps the note down onto the scale mask,
// and maps the result back to a signed Q1.15 sample.
// ----------------------------------------------------------------------------
//  port group   dir   payload                          beat rule
//  req_*        in    tdata[15:0] sample_in            tvalid & tready
//  rsp_*        out   tdata[15:0] sample_out           tvalid & tready
//  csr_*        in    wr_data[11:0] scale_mask         wr_en
//
//  One beat per clock while rsp is ready; req to rsp passes the stages below.
//  Stage one registers the sample, stage two holds octave and note, the
//  third applies the scale pick against the last note and drives rsp.
//  Each stage advances when the one after it is empty or moving, so a
//  stalled rsp still lets the pipe fill. Synchronous reset empties the pipe,
//  sets the mask to all notes and the last note to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cv_scale_quantizer_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [cvsq_pkg::SAMPLE_W-1:0] req_tdata,   // [15:0] sample_in
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [cvsq_pkg::SAMPLE_W-1:0]      rsp_tdata,   // [15:0] sample_out
   input  wire logic                          csr_wr_en,
   input  wire logic [cvsq_pkg::MASK_W-1:0]   csr_wr_data  // [11:0] scale_mask
);
   import cvsq_pkg::*;

   logic                  s1_valid_ff;
   logic [SAMPLE_W-1:0]   s1_sample_ff;
   logic                  s2_valid_ff;
   logic                  s2_neg_ff;
   logic [OCT_W-1:0]      s2_oct_ff;
   logic [NOTE_W-1:0]     s2_note_ff;
   logic                  rsp_valid_ff;
   logic [SAMPLE_W-1:0]   rsp_data_ff;
   logic [MASK_W-1:0]     mask_ff;
   logic [NOTE_W-1:0]     last_note_ff;

   logic                  rsp_move;
   logic                  s2_move;
   logic                  s1_move;

   logic                  s1_neg;
   logic [MAGIN_W-1:0]    mag_in;
   logic [PROD_W-1:0]     semis_prod;
   logic [SEMIS_W-1:0]    semis;
   logic [OPROD_W-1:0]    oct_prod;
   logic [OCT_W-1:0]      s2_oct_in;
   logic [NOTE_W-1:0]     s2_note_in;

   logic                  found;
   logic [NOTE_W-1:0]     sel_note;
   logic [NOTE_W-1:0]     last_note_in;
   logic [TOTAL_W-1:0]    total;
   logic [MAG_W-1:0]      mag;
   logic [MAG_W-1:0]      mag_sat;
   logic [SAMPLE_W-1:0]   rsp_data_in;

   assign rsp_move   = !rsp_valid_ff || rsp_tready;
   assign s2_move    = !s2_valid_ff || rsp_move;
   assign s1_move    = !s1_valid_ff || s2_move;
   assign req_tready = s1_move;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // stage two: magnitude to semitones, then octave and note
   always_comb begin
      s1_neg     = s1_sample_ff[SAMPLE_W-1];
      mag_in     = s1_neg ? (MAGIN_W'(1 << SAMPLE_W) - {1'b0, s1_sample_ff})
                          : {1'b0, s1_sample_ff};
      semis_prod = PROD_W'(mag_in) * PROD_W'(SPAN_SEMIS)
                 + PROD_W'(1 << (SAMPLE_W - 2));
      semis      = semis_prod[SAMPLE_W-1 +: SEMIS_W];
      oct_prod   = OPROD_W'(semis) * OPROD_W'(OCT_RECIP);
      s2_oct_in  = oct_prod[OCT_SHIFT +: OCT_W];
      s2_note_in = NOTE_W'(semis - SEMIS_W'(s2_oct_in * NOTES_PER_OCTAVE));
   end

   // stage three: highest scale note at or below the note, else the last one
   always_comb begin
      found    = 1'b0;
      sel_note = last_note_ff;
      for (int k = 0; k < MASK_W; k++) begin
         if (mask_ff[k] && (k <= int'(s2_note_ff))) begin
            found    = 1'b1;
            sel_note = NOTE_W'(k);
         end
      end
      last_note_in = sel_note;
      total        = TOTAL_W'(s2_oct_ff * NOTES_PER_OCTAVE) + TOTAL_W'(sel_note);
      mag          = MAG_LUT[total];
      if (s2_neg_ff) begin
         mag_sat     = (mag > NEG_FULL) ? NEG_FULL : mag;
         rsp_data_in = SAMPLE_W'(MAG_W'(1 << SAMPLE_W) - mag_sat);
      end else begin
         mag_sat     = (mag > POS_FULL) ? POS_FULL : mag;
         rsp_data_in = SAMPLE_W'(mag_sat);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= '1;
         last_note_ff <= '0;
      end else begin
         if (s1_move) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_move) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rsp_move) begin
            rsp_valid_ff <= s2_valid_ff;
            if (s2_valid_ff && found) begin
               last_note_ff <= last_note_in;
            end
         end
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_move && req_tvalid) begin
         s1_sample_ff <= req_tdata;
      end
      if (s2_move && s1_valid_ff) begin
         s2_neg_ff  <= s1_neg;
         s2_oct_ff  <= s2_oct_in;
         s2_note_ff <= s2_note_in;
      end
      if (rsp_move && s2_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
